FILE: rtl/skr_pkg.sv
package skr_pkg;

  localparam int DEPTH       = 64;
  localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_OUT_W = 7;

  localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_SRCH,
    S_SHIFT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

endpackage

FILE: rtl/skr_if.sv
interface skr_in_if;
  logic                               valid;
  logic                               ready;
  logic        [skr_pkg::KIND_W-1:0]  kind;
  logic signed [skr_pkg::KEY_W-1:0]   key_in;

  modport source (output valid, kind, key_in, input ready);
  modport sink   (input valid, kind, key_in, output ready);
endinterface

interface skr_out_if;
  logic                                   valid;
  logic                                   ready;
  logic        [skr_pkg::STATUS_W-1:0]    status;
  logic signed [skr_pkg::KEY_W-1:0]       key_out;
  logic        [skr_pkg::DEPTH_OUT_W-1:0] depth;

  modport source (output valid, status, key_out, depth, input ready);
  modport sink   (input valid, status, key_out, depth, output ready);
endinterface

FILE: rtl/stack_with_key_removal.sv
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    kind[1:0], key_in[31:0] signed
// out_ch   out  valid/ready    status[1:0], key_out[31:0] signed, depth[6:0]
//
// Push, empty pops and removes, and unused kinds go from accept to the finish state;
// pop on a non-empty stack reads the top entry in a read state first. Remove searches
// entries from the top down, then moves each entry above the match down one slot, then
// finishes; the single read port of the entry RAM sets this pace. Finish loads the result.
// Reset clears the count and control only; entry RAM is not cleared.
// One result waits in the output register while the next item is accepted;
// a later finished result holds the block until that register frees.
module stack_with_key_removal (
  input logic       clk,
  input logic       rst_n,
  skr_in_if.sink    in_ch,
  skr_out_if.source out_ch
);
  import skr_pkg::*;

  ram_req_t         ram_req;
  logic [KEY_W-1:0] ram_rdata;

  skr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  skr_ram #(
    .DATA_W (KEY_W),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: rtl/skr_ram.sv
module skr_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                             rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/skr_ctrl.sv
module skr_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  skr_in_if.sink                  in_ch,
  skr_out_if.source               out_ch,
  output skr_pkg::ram_req_t       ram_req,
  input  logic [skr_pkg::KEY_W-1:0] ram_rdata
);
  import skr_pkg::*;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PTR_W-1:0]     idx_r, idx_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [KEY_W-1:0]     res_key_r, res_key_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [KEY_W-1:0]     out_key_r, out_key_nxt;
  logic [DEPTH_OUT_W-1:0] out_depth_r, out_depth_nxt;

  logic             in_acc;
  logic             out_free;
  logic             hit;
  logic             at_top;
  logic             more;
  logic [PTR_W-1:0] top_idx;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign hit      = (ram_rdata == key_r);
  assign top_idx  = PTR_W'(cnt_r - CNT_W'(1));
  assign at_top   = (idx_r == top_idx);
  // another entry above the next write slot
  assign more     = ((CNT_W+1)'(idx_r) + (CNT_W+1)'(2)) < (CNT_W+1)'(cnt_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.kind == KIND_POP && cnt_r != '0) begin
            state_nxt = S_POP_RD;
          end else if (in_ch.kind == KIND_REMOVE && cnt_r != '0) begin
            state_nxt = S_SRCH;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_POP_RD: state_nxt = S_FINISH;
      S_SRCH: begin
        if (hit) begin
          state_nxt = at_top ? S_FINISH : S_SHIFT;
        end else if (idx_r == '0) begin
          state_nxt = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (!more) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_depth_nxt  = out_depth_r;
    ram_req.we     = 1'b0;
    ram_req.waddr  = idx_r;
    ram_req.wdata  = ram_rdata;
    ram_req.raddr  = idx_r;
    in_ch.ready    = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt        = in_ch.key_in;
          res_key_nxt    = '0;
          res_status_nxt = ST_OK;
          case (in_ch.kind)
            KIND_PUSH: begin
              if (cnt_r == CNT_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = PTR_W'(cnt_r);
                ram_req.wdata = in_ch.key_in;
                cnt_nxt       = cnt_r + CNT_W'(1);
              end
            end
            KIND_POP: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                ram_req.raddr = top_idx;
                cnt_nxt       = cnt_r - CNT_W'(1);
              end
            end
            KIND_REMOVE: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                ram_req.raddr = top_idx;
                idx_nxt       = top_idx;
              end
            end
            default: res_status_nxt = ST_OK;
          endcase
        end
      end
      S_POP_RD: res_key_nxt = ram_rdata;
      S_SRCH: begin
        if (hit) begin
          if (at_top) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end else begin
            ram_req.raddr = idx_r + PTR_W'(1);
          end
        end else if (idx_r == '0) begin
          res_status_nxt = ST_NOTFOUND;
        end else begin
          idx_nxt       = idx_r - PTR_W'(1);
          ram_req.raddr = idx_r - PTR_W'(1);
        end
      end
      S_SHIFT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r;
        ram_req.wdata = ram_rdata;
        ram_req.raddr = idx_r + PTR_W'(2);
        idx_nxt       = idx_r + PTR_W'(1);
        if (!more) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_depth_nxt  = DEPTH_OUT_W'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.key_out = out_key_r;
  assign out_ch.depth   = out_depth_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("count above capacity");

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (state_r == S_IDLE || state_r == S_SHIFT))
    else $error("entry write outside push or shift");

  a_pop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.kind == KIND_POP && cnt_r != '0)
      |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("pop did not lower count");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> ((CNT_W+1)'(idx_r) + (CNT_W+1)'(1)) < (CNT_W+1)'(cnt_r))
    else $error("shift beyond top");

endmodule
